[sv/ssq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and codes for the stable sorted priority queue core.
// ----------------------------------------------------------------------------
package ssq_pkg;

    // Operation selector carried on s_tuser.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    // Result status carried on m_tuser.
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    localparam int KIND_W  = 16;
    localparam int PRIO_W  = 32;
    localparam int COUNT_W = 7;
    localparam int PORT_HANDLE_W = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted input transaction
        logic eval;    // register the slot compares
        logic commit;  // update the slots and the result register
    } ssq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // result register empty or being drained this cycle
    } ssq_sts_t;

endpackage

[sv/ssq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_ctrl
// Sequencer: accept an operation, evaluate the compares, commit the result.
// ----------------------------------------------------------------------------
module ssq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ssq_pkg::ssq_sts_t sts,
    output ssq_pkg::ssq_cmd_t cmd
);
    import ssq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.eval   = (state_reg == S_EVAL);
    assign cmd.commit = (state_reg == S_COMMIT) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // Hold the operation until the result register can take it.
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/ssq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_datapath
// Sorted slot array with parallel compares, shift insert and shift remove.
// ----------------------------------------------------------------------------
module ssq_datapath #(
    parameter int CAPACITY    = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ssq_pkg::ssq_cmd_t cmd,
    output ssq_pkg::ssq_sts_t sts,
    input  logic              in_opcode,
    input  logic [15:0]       in_handle,
    input  logic [15:0]       in_kind,
    input  logic [31:0]       in_priority,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [2:0]        m_tuser,
    output logic [71:0]       m_tdata
);
    import ssq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    // Captured operation.
    opcode_t                  op_reg;
    logic [HANDLE_BITS-1:0]   hin_reg;
    logic [KIND_W-1:0]        kin_reg;
    logic signed [PRIO_W-1:0] pin_reg;

    // Slot array, slot 0 is the front of the queue.
    logic [HANDLE_BITS-1:0]   hnd_reg [CAPACITY];
    logic [KIND_W-1:0]        knd_reg [CAPACITY];
    logic signed [PRIO_W-1:0] pri_reg [CAPACITY];
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;

    // Registered compare results.
    logic                     dup_reg;
    logic                     dup_next;
    logic [CAPACITY-1:0]      le_reg;
    logic [CAPACITY-1:0]      le_next;
    logic [CAPACITY-1:0]      prev_le;

    // Next slot values for each kind of update.
    logic [HANDLE_BITS-1:0]   ins_h [CAPACITY];
    logic [KIND_W-1:0]        ins_k [CAPACITY];
    logic signed [PRIO_W-1:0] ins_p [CAPACITY];
    logic [HANDLE_BITS-1:0]   dn_h  [CAPACITY];
    logic [KIND_W-1:0]        dn_k  [CAPACITY];
    logic signed [PRIO_W-1:0] dn_p  [CAPACITY];

    // Result register.
    logic                     m_valid_reg;
    status_t                  st_reg;
    status_t                  st_next;
    logic [COUNT_W-1:0]       cnt_reg;
    logic [PORT_HANDLE_W-1:0] oh_reg;
    logic [PORT_HANDLE_W-1:0] oh_next;
    logic [KIND_W-1:0]        ok_reg;
    logic [KIND_W-1:0]        ok_next;
    logic [PRIO_W-1:0]        op_pri_reg;
    logic [PRIO_W-1:0]        op_pri_next;

    logic queue_full;
    logic do_insert;
    logic do_remove;

    assign sts.out_free = !m_valid_reg || m_tready;

    // Parallel compares against every occupied slot.
    always_comb begin
        dup_next = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            le_next[i] = (OCC_W'(i) < occ_reg) && (pri_reg[i] <= pin_reg);
            if ((OCC_W'(i) < occ_reg) && (hnd_reg[i] == hin_reg)) begin
                dup_next = 1'b1;
            end
        end
    end

    // The new entry lands at the first slot whose priority is greater.
    assign prev_le = {le_reg[CAPACITY-2:0], 1'b1};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        if (g == 0) begin : g_front
            assign ins_h[g] = le_reg[g] ? hnd_reg[g] : hin_reg;
            assign ins_k[g] = le_reg[g] ? knd_reg[g] : kin_reg;
            assign ins_p[g] = le_reg[g] ? pri_reg[g] : pin_reg;
        end else begin : g_rest
            assign ins_h[g] = le_reg[g] ? hnd_reg[g] :
                              (prev_le[g] ? hin_reg : hnd_reg[g-1]);
            assign ins_k[g] = le_reg[g] ? knd_reg[g] :
                              (prev_le[g] ? kin_reg : knd_reg[g-1]);
            assign ins_p[g] = le_reg[g] ? pri_reg[g] :
                              (prev_le[g] ? pin_reg : pri_reg[g-1]);
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign dn_h[g] = hnd_reg[g];
            assign dn_k[g] = knd_reg[g];
            assign dn_p[g] = pri_reg[g];
        end else begin : g_body
            assign dn_h[g] = hnd_reg[g+1];
            assign dn_k[g] = knd_reg[g+1];
            assign dn_p[g] = pri_reg[g+1];
        end
    end

    assign queue_full = (occ_reg == OCC_W'(CAPACITY));

    always_comb begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        occ_next    = occ_reg;
        st_next     = ST_EMPTY;
        oh_next     = '0;
        ok_next     = '0;
        op_pri_next = '0;
        if (op_reg == OP_INSERT) begin
            if ((hin_reg == '0) || dup_reg) begin
                st_next = ST_REJECTED;
            end else if (queue_full) begin
                st_next = ST_FULL;
            end else begin
                st_next   = ST_INSERTED;
                do_insert = cmd.commit;
                occ_next  = occ_reg + 1'b1;
            end
        end else if (occ_reg == '0) begin
            st_next = ST_EMPTY;
        end else begin
            st_next     = ST_REMOVED;
            do_remove   = cmd.commit;
            occ_next    = occ_reg - 1'b1;
            oh_next     = PORT_HANDLE_W'(hnd_reg[0]);
            ok_next     = knd_reg[0];
            op_pri_next = pri_reg[0];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                occ_reg     <= occ_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= opcode_t'(in_opcode);
            hin_reg <= HANDLE_BITS'(in_handle);
            kin_reg <= in_kind;
            pin_reg <= in_priority;
        end
        if (cmd.eval) begin
            dup_reg <= dup_next;
            le_reg  <= le_next;
        end
        if (do_insert) begin
            hnd_reg <= ins_h;
            knd_reg <= ins_k;
            pri_reg <= ins_p;
        end else if (do_remove) begin
            hnd_reg <= dn_h;
            knd_reg <= dn_k;
            pri_reg <= dn_p;
        end
        if (cmd.commit) begin
            st_reg     <= st_next;
            cnt_reg    <= COUNT_W'(occ_next);
            oh_reg     <= oh_next;
            ok_reg     <= ok_next;
            op_pri_reg <= op_pri_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = st_reg;
    assign m_tdata  = {1'b0, op_pri_reg, ok_reg, oh_reg, cnt_reg};

endmodule

[sv/stable_sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// Bounded stable minimum-priority queue with insert and remove-front.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on the s_ channel is one operation, selected by
//   s_tuser (insert or remove front). Each operation yields exactly one
//   result transaction on the m_ channel with a status code on m_tuser and
//   the occupancy after the operation plus the removed entry on m_tdata.
//   Entries are kept in slot registers ordered by ascending signed priority;
//   equal priorities leave in arrival order.
//   The result is registered through three steps: capture at acceptance,
//   compare against all slots, and commit with slot shift.
//   The three-step sequencer handles one operation at a time, so the next
//   operation is accepted only once the previous one has committed.
//   A new operation is accepted while a previous result still waits; when
//   m_tready is held low, the commit step waits and s_tready stays low.
//   Reset empties the queue and drops any pending result; slot contents are
//   not cleared, only the occupancy count.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_core #(
    parameter int CAPACITY    = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [0:0]  s_tuser,   // opcode
    input  logic [63:0] s_tdata,   // item_handle, kind, priority_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // status
    output logic [71:0] m_tdata    // count, out_handle, out_kind, out_priority
);
    import ssq_pkg::*;

    ssq_cmd_t cmd;
    ssq_sts_t sts;

    ssq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssq_datapath #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_opcode   (s_tuser[0]),
        .in_handle   (s_tdata[15:0]),
        .in_kind     (s_tdata[31:16]),
        .in_priority (s_tdata[63:32]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

endmodule
